// File: src/position_bin_offset_index_macros.svh
// Assertion macros used by the checker file of the bin offset index.
`ifndef POSITION_BIN_OFFSET_INDEX_MACROS_SVH
`define POSITION_BIN_OFFSET_INDEX_MACROS_SVH

// A property that must hold in every cycle outside reset.
`define PBOI_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition in one cycle that must be followed by another in the next cycle.
`define PBOI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/pboi_pkg.sv
package pboi_pkg;

   // Field widths of the transactions.
   localparam int POS_W    = 32;
   localparam int LEN_W    = 9;
   localparam int INDEX_W  = 10;
   localparam int WIDTH_W  = 32;
   localparam int BIN_W    = 43;
   localparam int FIRST_W  = 40;
   localparam int COUNT_W  = 32;
   localparam int STEP_W   = LEN_W + 1;
   localparam int PROD_W   = INDEX_W + WIDTH_W;
   localparam int EXT_W    = 64;

   // Reset value of the bin width register.
   localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = 32'd50000;

   // Command codes carried in a request transaction.
   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   typedef struct packed {
      logic               command;
      logic [POS_W-1:0]   position;
      logic [LEN_W-1:0]   record_length;
      logic [INDEX_W-1:0] bin_index;
   } req_type;

   typedef struct packed {
      logic               bin_occupied;
      logic [BIN_W-1:0]   bin_start;
      logic [BIN_W-1:0]   bin_end;
      logic [FIRST_W-1:0] first_offset;
      logic [COUNT_W-1:0] record_count;
      logic               table_overflow;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load;
      logic div_start;
      logic capture_quot;
      logic mem_read;
      logic rec_update;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic req_is_read;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// File: src/position_bin_offset_index.sv
// A record transaction runs through acceptance, 32 steps of the restoring divider,
// the done cycle that captures the bin, a registered bin store read and the update
// write. A read transaction reaches the output register through the store read
// with the bin start multiply, then the load, which waits while an earlier
// response is still held; one transaction is worked at a time.
// Synchronous reset clears offset, overflow flag, bin width to 50000; a clearing pass holds req_ready low.
module position_bin_offset_index #(
   parameter int NUM_BINS    = 1024,
   parameter int OFFSET_BITS = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  pboi_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pboi_pkg::rsp_type            rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [pboi_pkg::WIDTH_W-1:0] csr_write_data
);

   pboi_pkg::cmd_type    cmd;
   pboi_pkg::status_type status;

   // Sequencing of each transaction.
   pboi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Bin store, divider, offset tracking and output register.
   pboi_datapath #(
      .NUM_BINS    (NUM_BINS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload)
   );

endmodule

// File: src/pboi_divider.sv
module pboi_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pboi_pkg::POS_W-1:0]   dividend,
   input  logic [pboi_pkg::WIDTH_W-1:0] divisor,
   output logic                         done,
   output logic [pboi_pkg::POS_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(pboi_pkg::POS_W);

   logic                         busy_ff;
   logic                         done_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [pboi_pkg::WIDTH_W-1:0] rem_ff, rem_in;
   logic [pboi_pkg::POS_W-1:0]   dvd_ff, dvd_in;
   logic [pboi_pkg::WIDTH_W-1:0] div_ff;
   logic [pboi_pkg::WIDTH_W:0]   trial;
   logic [pboi_pkg::WIDTH_W:0]   diff;

   // One restoring step per cycle; the quotient bits shift into the dividend
   // register from the right. A zero divisor yields an all-ones quotient.
   always_comb begin
      trial = {rem_ff, dvd_ff[pboi_pkg::POS_W-1]};
      diff  = trial - {1'b0, div_ff};
      if (!diff[pboi_pkg::WIDTH_W]) begin
         rem_in = diff[pboi_pkg::WIDTH_W-1:0];
         dvd_in = {dvd_ff[pboi_pkg::POS_W-2:0], 1'b1};
      end else begin
         rem_in = trial[pboi_pkg::WIDTH_W-1:0];
         dvd_in = {dvd_ff[pboi_pkg::POS_W-2:0], 1'b0};
      end
   end

   // Step sequencing and the done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(pboi_pkg::POS_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand and partial remainder registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// File: src/pboi_datapath.sv
module pboi_datapath #(
   parameter int NUM_BINS    = 1024,
   parameter int OFFSET_BITS = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pboi_pkg::cmd_type            cmd,
   output pboi_pkg::status_type         status,
   input  pboi_pkg::req_type            req_payload,
   input  logic                         csr_write_enable,
   input  logic [pboi_pkg::WIDTH_W-1:0] csr_write_data,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output pboi_pkg::rsp_type            rsp_payload
);

   localparam int AW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int SUM_W = OFFSET_BITS + 1;

   logic [pboi_pkg::WIDTH_W-1:0] width_ff;
   pboi_pkg::req_type            req_ff;
   logic [AW-1:0]                addr_ff;
   logic                         in_range_ff;
   logic [AW-1:0]                clear_addr_ff;
   logic [OFFSET_BITS-1:0]       offset_ff, offset_in;
   logic                         overflow_ff;
   logic                         rd_valid_ff;
   logic [OFFSET_BITS-1:0]       rd_first_ff;
   logic [pboi_pkg::COUNT_W-1:0] rd_tally_ff;
   logic [pboi_pkg::PROD_W-1:0]  product_ff;
   logic                         rsp_valid_ff;
   pboi_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                         valid_mem [NUM_BINS];
   logic [OFFSET_BITS-1:0]       first_mem [NUM_BINS];
   logic [pboi_pkg::COUNT_W-1:0] tally_mem [NUM_BINS];

   logic                         div_done;
   logic [pboi_pkg::POS_W-1:0]   quotient;
   logic [pboi_pkg::POS_W-1:0]   index_ext;
   logic [pboi_pkg::STEP_W-1:0]  step;
   logic [SUM_W-1:0]             offset_sum;
   logic [pboi_pkg::COUNT_W-1:0] tally_next;
   logic [pboi_pkg::EXT_W-1:0]   first_ext;

   // Iterative divider for the bin number.
   pboi_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (req_payload.position),
      .divisor  (width_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Bin width register.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= pboi_pkg::BIN_WIDTH_RESET;
      end else if (csr_write_enable) begin
         width_ff <= csr_write_data;
      end
   end

   // Captured request and the bin address it selects.
   assign index_ext = pboi_pkg::POS_W'(req_payload.bin_index);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_payload;
         addr_ff     <= index_ext[AW-1:0];
         in_range_ff <= index_ext < pboi_pkg::POS_W'(NUM_BINS);
      end else if (cmd.capture_quot) begin
         addr_ff     <= quotient[AW-1:0];
         in_range_ff <= quotient < pboi_pkg::POS_W'(NUM_BINS);
      end
   end

   // Clearing pass over the valid store after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   // Registered reads of the bin store, with the bin start product alongside.
   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_valid_ff <= valid_mem[addr_ff];
         rd_first_ff <= first_mem[addr_ff];
         rd_tally_ff <= tally_mem[addr_ff];
         product_ff  <= pboi_pkg::PROD_W'(req_ff.bin_index) *
                        pboi_pkg::PROD_W'(width_ff);
      end
   end

   // Record count: one for an empty bin, else a saturating increment.
   always_comb begin
      if (!rd_valid_ff) begin
         tally_next = pboi_pkg::COUNT_W'(1);
      end else if (rd_tally_ff == '1) begin
         tally_next = rd_tally_ff;
      end else begin
         tally_next = rd_tally_ff + 1'b1;
      end
   end

   // Valid store writes: cleared by the pass, set by a record.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         valid_mem[clear_addr_ff] <= 1'b0;
      end else if (cmd.rec_update && in_range_ff) begin
         valid_mem[addr_ff] <= 1'b1;
      end
   end

   // First offset and count writes.
   always_ff @(posedge clock) begin
      if (cmd.rec_update && in_range_ff && !rd_valid_ff) begin
         first_mem[addr_ff] <= offset_ff;
      end
      if (cmd.rec_update && in_range_ff) begin
         tally_mem[addr_ff] <= tally_next;
      end
   end

   // Running offset advances by the line length plus the newline, saturating.
   assign step       = pboi_pkg::STEP_W'(req_ff.record_length) + 1'b1;
   assign offset_sum = {1'b0, offset_ff} + SUM_W'(step);
   assign offset_in  = offset_sum[OFFSET_BITS] ? '1 : offset_sum[OFFSET_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.rec_update) begin
         offset_ff <= offset_in;
         if (!in_range_ff) begin
            overflow_ff <= 1'b1;
         end
      end
   end

   // Assemble the response of a read.
   assign first_ext = pboi_pkg::EXT_W'(rd_first_ff);

   always_comb begin
      rsp_data_in.bin_occupied   = in_range_ff && rd_valid_ff;
      rsp_data_in.bin_start      = pboi_pkg::BIN_W'(product_ff);
      rsp_data_in.bin_end        = pboi_pkg::BIN_W'(product_ff) +
                                   pboi_pkg::BIN_W'(width_ff);
      rsp_data_in.first_offset   = rsp_data_in.bin_occupied ?
                                   first_ext[pboi_pkg::FIRST_W-1:0] : '0;
      rsp_data_in.record_count   = rsp_data_in.bin_occupied ? rd_tally_ff : '0;
      rsp_data_in.table_overflow = overflow_ff;
   end

   // Output register: a response waits here until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Status towards the controller.
   assign status.clear_last  = clear_addr_ff == AW'(NUM_BINS - 1);
   assign status.req_is_read = req_payload.command == pboi_pkg::CMD_READ;
   assign status.div_done    = div_done;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

// File: src/pboi_ctrl.sv
module pboi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pboi_pkg::status_type status,
   output pboi_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR      = 3'd0;
   localparam logic [2:0] S_IDLE       = 3'd1;
   localparam logic [2:0] S_DIV        = 3'd2;
   localparam logic [2:0] S_REC_FETCH  = 3'd3;
   localparam logic [2:0] S_REC_UPDATE = 3'd4;
   localparam logic [2:0] S_RD_FETCH   = 3'd5;
   localparam logic [2:0] S_RD_DONE    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;

   // Next state and the commands issued in each state.
   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (status.req_is_read) begin
                  state_in = S_RD_FETCH;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.capture_quot = 1'b1;
               state_in         = S_REC_FETCH;
            end
         end
         S_REC_FETCH: begin
            cmd.mem_read = 1'b1;
            state_in     = S_REC_UPDATE;
         end
         S_REC_UPDATE: begin
            cmd.rec_update = 1'b1;
            state_in       = S_IDLE;
         end
         S_RD_FETCH: begin
            cmd.mem_read = 1'b1;
            state_in     = S_RD_DONE;
         end
         S_RD_DONE: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/pboi_checker.sv
`include "position_bin_offset_index_macros.svh"

module pboi_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input pboi_pkg::req_type            req_payload,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input pboi_pkg::rsp_type            rsp_payload,
   input logic                         csr_write_enable,
   input logic [pboi_pkg::WIDTH_W-1:0] csr_write_data
);

   logic [pboi_pkg::WIDTH_W-1:0] width_ff;
   logic                         overflow_ff;
   logic [1:0]                   pending_ff;
   logic                         read_accept;
   logic                         rsp_accept;

   assign read_accept = req_valid && req_ready && req_payload.command == pboi_pkg::CMD_READ;
   assign rsp_accept  = rsp_valid && rsp_ready;

   // Shadow of the bin width, the overflow flag seen so far and open reads.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= pboi_pkg::BIN_WIDTH_RESET;
         overflow_ff <= 1'b0;
         pending_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            width_ff <= csr_write_data;
         end
         if (rsp_accept && rsp_payload.table_overflow) begin
            overflow_ff <= 1'b1;
         end
         if (read_accept && !rsp_accept) begin
            pending_ff <= pending_ff + 1'b1;
         end else if (rsp_accept && !read_accept) begin
            pending_ff <= pending_ff - 1'b1;
         end
      end
   end

   `PBOI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response dropped or changed while stalled")
   `PBOI_ASSERT_ALWAYS(a_rsp_has_read, !rsp_valid || pending_ff != 2'd0, "response without an open read transaction")
   `PBOI_ASSERT_ALWAYS(a_overflow_sticky, !rsp_valid || !overflow_ff || rsp_payload.table_overflow, "overflow flag cleared after being reported")
   `PBOI_ASSERT_ALWAYS(a_bin_end, !rsp_valid || rsp_payload.bin_end == rsp_payload.bin_start + pboi_pkg::BIN_W'(width_ff), "bin end is not start plus width")
   `PBOI_ASSERT_ALWAYS(a_empty_bin, !rsp_valid || rsp_payload.bin_occupied || (rsp_payload.first_offset == '0 && rsp_payload.record_count == '0), "empty bin reports data")

endmodule

bind position_bin_offset_index pboi_checker u_checker (.*);

// File: tb/position_bin_offset_index_checker.sv
// Watches the request, result and register ports of the bin offset index.
// It keeps its own copy of the bin store and predicts each bin read.
module position_bin_offset_index_checker #(
   parameter int NUM_BINS    = 1024,
   parameter int OFFSET_BITS = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  pboi_pkg::req_type            req_payload,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  pboi_pkg::rsp_type            rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [pboi_pkg::WIDTH_W-1:0] csr_write_data,
   output int                           failures,
   output int                           pending,
   output int                           records_seen,
   output int                           dropped_seen,
   output int                           reads_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] OFFSET_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;
   localparam logic [pboi_pkg::COUNT_W-1:0] COUNT_LIMIT = '1;

   // Shadow copy of the bin store and the running state.
   logic                         bin_used [NUM_BINS];
   logic [63:0]                  bin_first_offset [NUM_BINS];
   logic [pboi_pkg::COUNT_W-1:0] bin_records [NUM_BINS];
   logic [63:0]                  line_offset;
   logic                         overflow_flag;
   logic [pboi_pkg::WIDTH_W-1:0] width_setting;
   pboi_pkg::rsp_type            bin_reads_due [$];

   // A record lands in its bin, or is dropped when the bin lies past the table.
   task automatic log_record(input pboi_pkg::req_type item);
      logic [63:0] bin;
      logic [63:0] step;
      // A zero width makes the divider give all ones, which is past the table.
      bin  = (width_setting == '0) ? 64'hFFFF_FFFF : 64'(item.position / width_setting);
      step = 64'(item.record_length) + 64'd1;
      if (bin < 64'(NUM_BINS)) begin
         if (!bin_used[bin]) begin
            bin_used[bin]         = 1'b1;
            bin_first_offset[bin] = line_offset;
            bin_records[bin]      = 1;
         end else if (bin_records[bin] != COUNT_LIMIT) begin
            bin_records[bin]++;
         end
      end else begin
         overflow_flag = 1'b1;
         dropped_seen++;
      end
      // The running offset saturates rather than wrapping.
      if (line_offset > OFFSET_LIMIT - step) begin
         line_offset = OFFSET_LIMIT;
      end else begin
         line_offset += step;
      end
      records_seen++;
   endtask

   // Expected report for one bin read.
   function automatic pboi_pkg::rsp_type predict_bin_read(input pboi_pkg::req_type item);
      pboi_pkg::rsp_type report;
      logic [63:0]       start;
      start  = 64'(item.bin_index) * 64'(width_setting);
      report = '0;
      report.bin_start      = start[pboi_pkg::BIN_W-1:0];
      report.bin_end        = pboi_pkg::BIN_W'(start + 64'(width_setting));
      report.table_overflow = overflow_flag;
      if (64'(item.bin_index) < 64'(NUM_BINS) && bin_used[item.bin_index]) begin
         report.bin_occupied = 1'b1;
         report.first_offset = bin_first_offset[item.bin_index][pboi_pkg::FIRST_W-1:0];
         report.record_count = bin_records[item.bin_index];
      end
      return report;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Results are checked before new requests are predicted, so that a result
   // and a fresh read in the same cycle keep their order.
   always @(posedge clock) begin
      pboi_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            bin_used[i]         = 1'b0;
            bin_first_offset[i] = '0;
            bin_records[i]      = '0;
         end
         line_offset   = '0;
         overflow_flag = 1'b0;
         width_setting = pboi_pkg::BIN_WIDTH_RESET;
         bin_reads_due.delete();
         failures      = 0;
         records_seen  = 0;
         dropped_seen  = 0;
         reads_seen    = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (bin_reads_due.size() == 0) begin
               failures++;
               $display("%0t ns: result transaction, expected none, actual %p",
                        $time, rsp_payload);
            end else begin
               want = bin_reads_due.pop_front();
               check_field("bin_occupied", 64'(want.bin_occupied),
                           64'(rsp_payload.bin_occupied));
               check_field("bin_start", 64'(want.bin_start), 64'(rsp_payload.bin_start));
               check_field("bin_end", 64'(want.bin_end), 64'(rsp_payload.bin_end));
               check_field("first_offset", 64'(want.first_offset),
                           64'(rsp_payload.first_offset));
               check_field("record_count", 64'(want.record_count),
                           64'(rsp_payload.record_count));
               check_field("table_overflow", 64'(want.table_overflow),
                           64'(rsp_payload.table_overflow));
            end
         end
         if (csr_write_enable) begin
            width_setting = csr_write_data;
         end
         if (req_valid && req_ready) begin
            if (req_payload.command == pboi_pkg::CMD_RECORD) begin
               log_record(req_payload);
            end else begin
               bin_reads_due.insert(bin_reads_due.size(), predict_bin_read(req_payload));
               reads_seen++;
            end
         end
      end
      pending = bin_reads_due.size();
   end

endmodule

// File: tb/position_bin_offset_index_tb.sv
// Drives record and read transactions into the bin offset index under a range
// of bin widths, with random gaps on both channels; the checker does the rest.
module position_bin_offset_index_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BINS      = 1024;
   localparam int SETTLE_CYCLES = 48;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   pboi_pkg::req_type            req_payload;
   logic                         rsp_valid;
   logic                         rsp_ready;
   pboi_pkg::rsp_type            rsp_payload;
   logic                         csr_write_enable;
   logic [pboi_pkg::WIDTH_W-1:0] csr_write_data;

   int                           failures;
   int                           pending;
   int                           records_seen;
   int                           dropped_seen;
   int                           reads_seen;
   int                           width_settings = 0;
   logic [pboi_pkg::WIDTH_W-1:0] width_now;
   bit                           send_quiet = 1'b1;
   bit                           recv_quiet = 1'b1;

   position_bin_offset_index #(
      .NUM_BINS(NUM_BINS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   position_bin_offset_index_checker #(
      .NUM_BINS(NUM_BINS)
   ) bin_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .failures        (failures),
      .pending         (pending),
      .records_seen    (records_seen),
      .dropped_seen    (dropped_seen),
      .reads_seen      (reads_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #600us;
      $display("Verification failed");
      $finish;
   end

   // Result side: a fresh stall is drawn before each result transaction.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = recv_quiet ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
      end
   end

   // Presents one request transaction; entered and left at a falling edge.
   task automatic send_item(input pboi_pkg::req_type item);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_record(input logic [pboi_pkg::POS_W-1:0] position,
                              input logic [pboi_pkg::LEN_W-1:0] len);
      pboi_pkg::req_type item;
      item.command       = pboi_pkg::CMD_RECORD;
      item.position      = position;
      item.record_length = len;
      item.bin_index     = pboi_pkg::INDEX_W'($urandom);
      send_item(item);
   endtask

   task automatic send_read(input logic [pboi_pkg::INDEX_W-1:0] index);
      pboi_pkg::req_type item;
      item.command       = pboi_pkg::CMD_READ;
      item.position      = $urandom;
      item.record_length = pboi_pkg::LEN_W'($urandom);
      item.bin_index     = index;
      send_item(item);
   endtask

   // Holds off until every read has reported and the last record has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_bin_width(input logic [pboi_pkg::WIDTH_W-1:0] value);
      wait_idle();
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      width_now = value;
      width_settings++;
   endtask

   // Mostly records that hit the table, clustered on a few hot bins, with
   // some fully random coordinates that tend to fall past the table, and bin reads.
   task automatic random_item();
      int unsigned                  pick;
      int unsigned                  bin;
      logic [63:0]                  base;
      logic [63:0]                  span;
      logic [pboi_pkg::POS_W-1:0]   position;
      logic [pboi_pkg::LEN_W-1:0]   len;
      pick = $urandom_range(0, 9);
      len  = (pick == 0) ? pboi_pkg::LEN_W'(0) :
             (pick == 1) ? pboi_pkg::LEN_W'(499) : pboi_pkg::LEN_W'($urandom_range(0, 499));
      if ($urandom_range(0, 99) < 35) begin
         send_read($urandom_range(0, 1) ? pboi_pkg::INDEX_W'($urandom_range(0, 15))
                                        : pboi_pkg::INDEX_W'($urandom_range(0, NUM_BINS - 1)));
      end else begin
         pick     = $urandom_range(0, 9);
         position = $urandom;
         if (pick >= 2 && width_now != '0) begin
            bin  = (pick < 5) ? $urandom_range(0, 15) : $urandom_range(0, NUM_BINS - 1);
            base = 64'(bin) * 64'(width_now);
            if (base <= 64'hFFFF_FFFF) begin
               span = 64'(width_now) - 64'd1;
               if (span > 64'hFFFF_FFFF - base) begin
                  span = 64'hFFFF_FFFF - base;
               end
               position = pboi_pkg::POS_W'(base + 64'($urandom_range(0, span[31:0])));
            end
         end
         send_record(position, len);
      end
   endtask

   task automatic random_phase(input int count, input logic [pboi_pkg::WIDTH_W-1:0] width);
      write_bin_width(width);
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      repeat (count) random_item();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      width_now        = pboi_pkg::BIN_WIDTH_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset bin width: empty bins, the first and last
      // bins, the longest and shortest lines, and bins past the table.
      send_read(pboi_pkg::INDEX_W'(0));
      send_read(pboi_pkg::INDEX_W'(NUM_BINS - 1));
      send_record(32'd0, 9'd0);
      send_record(32'd49_999, 9'd499);
      send_record(32'd50_000, 9'd256);
      send_record(32'd51_199_999, 9'd1);
      send_read(pboi_pkg::INDEX_W'(0));
      send_read(pboi_pkg::INDEX_W'(1));
      send_read(pboi_pkg::INDEX_W'(NUM_BINS - 1));
      send_record(32'd51_200_000, 9'd10);
      send_record(32'hFFFF_FFFF, 9'd499);
      send_read(pboi_pkg::INDEX_W'(1));
      send_read(pboi_pkg::INDEX_W'(2));

      // A zero width sends every record past the table.
      write_bin_width('0);
      send_record(32'd0, 9'd7);
      send_record(32'hFFFF_FFFF, 9'd0);
      send_read(pboi_pkg::INDEX_W'(0));
      send_read(pboi_pkg::INDEX_W'(NUM_BINS - 1));

      // The widest setting gives the largest bin start and end.
      write_bin_width('1);
      send_record(32'hFFFF_FFFF, 9'd3);
      send_record(32'hFFFF_FFFE, 9'd4);
      send_read(pboi_pkg::INDEX_W'(0));
      send_read(pboi_pkg::INDEX_W'(1));
      send_read(pboi_pkg::INDEX_W'(NUM_BINS - 1));

      // Random part over a spread of widths.
      random_phase(100, 32'd1);
      random_phase(100, pboi_pkg::WIDTH_W'($urandom_range(2, 64)));
      random_phase(100, pboi_pkg::WIDTH_W'($urandom_range(1000, 100_000)));
      random_phase(40, '0);
      random_phase(100, pboi_pkg::BIN_WIDTH_RESET);
      random_phase(100, pboi_pkg::WIDTH_W'($urandom));
      random_phase(80, '1);
      random_phase(60, pboi_pkg::WIDTH_W'($urandom_range(100, 4_000_000)));

      // Drain and let the last record settle.
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d record transactions (%0d past the table) and %0d bin reads.",
               records_seen, dropped_seen, reads_seen);
      $display("Bin width was rewritten %0d times, zero and all ones among the settings.",
               width_settings);
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
